[rtl/cmvig_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cmvig_pkg;

  localparam int MAX_HORZ   = 64;
  localparam int MAX_CAP    = 32;
  localparam int DIV1_STEPS = 6;
  localparam int DIV2_STEPS = 17;
  localparam int NUM_LANES  = 3;
  localparam int SIN_LAT    = 6;
  // accept edge to the edge that samples done_o
  localparam int LATENCY    = DIV1_STEPS + 1 + DIV2_STEPS + SIN_LAT + 2;

  localparam logic REG_HORZ = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_QUAD   = 1'b1;

  localparam logic [28:0] SIN_C1 = 29'd421657428;
  localparam logic [27:0] SIN_C3 = 28'd173399667;
  localparam logic [24:0] SIN_C5 = 25'd21392326;
  localparam logic [20:0] SIN_C7 = 21'd1214631;

  typedef enum logic [1:0] {
    RG_NONE,
    RG_MANTLE,
    RG_TOP,
    RG_BOTTOM
  } region_e;

  // one restoring-division lane: partial remainder, numerator bits still to
  // bring down, quotient so far, divisor
  typedef struct packed {
    logic [6:0]  rem;
    logic [16:0] num;
    logic [16:0] quo;
    logic [6:0]  den;
  } lane_t;

  typedef struct packed {
    logic        func;
    region_e     region;
    logic        w;
    logic [12:0] idx;
    logic [14:0] tu;
    logic [14:0] tv;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
    logic [15:0] cd;
  } ctx_t;

  typedef struct packed {
    logic                  vld;
    ctx_t                  ctx;
    lane_t [NUM_LANES-1:0] lane;
  } cell_t;

endpackage

`default_nettype wire

[rtl/cmvig_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmvig_div_cell import cmvig_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cell_t cell_i,
  output cell_t      cell_o
);

  cell_t cell_d;

  always_comb begin
    logic [7:0] t;
    logic [7:0] diff;
    logic       ge;
    cell_d = cell_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      t    = {cell_i.lane[l].rem, cell_i.lane[l].num[16]};
      diff = t - {1'b0, cell_i.lane[l].den};
      ge   = (t >= {1'b0, cell_i.lane[l].den});
      cell_d.lane[l].rem = ge ? diff[6:0] : t[6:0];
      cell_d.lane[l].num = {cell_i.lane[l].num[15:0], 1'b0};
      cell_d.lane[l].quo = {cell_i.lane[l].quo[15:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else begin
      cell_o <= cell_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cmvig_sin.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmvig_sin import cmvig_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [15:0] phase_i,
  output logic signed [15:0] sin_o
);

  logic [1:0]  q1_q, q2_q, q3_q, q4_q, q5_q;
  logic [14:0] z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [14:0] zs2_q, zs3_q, zs4_q;
  logic [24:0] t5_q;
  logic [27:0] t3_q;
  logic [28:0] t1_q;

  logic [30:0] zsq;
  logic [35:0] p3;
  logic [39:0] p4;
  logic [42:0] p5;
  logic [43:0] p6;
  logic [14:0] m;

  assign zsq = {16'b0, z1_q} * {16'b0, z1_q} + 31'd8192;
  assign p3  = SIN_C7 * zs2_q;
  assign p4  = t5_q * zs3_q;
  assign p5  = t3_q * zs4_q;
  assign p6  = t1_q * z5_q + 44'd134217728;
  assign m   = p6[42:28];

  always_ff @(posedge clk_i) begin
    // fold to a quarter wave
    q1_q  <= phase_i[15:14];
    z1_q  <= phase_i[14] ? (15'd16384 - {1'b0, phase_i[13:0]}) : {1'b0, phase_i[13:0]};
    q2_q  <= q1_q;
    z2_q  <= z1_q;
    zs2_q <= zsq[28:14];
    q3_q  <= q2_q;
    z3_q  <= z2_q;
    zs3_q <= zs2_q;
    t5_q  <= SIN_C5 - {3'b0, p3[35:14]};
    q4_q  <= q3_q;
    z4_q  <= z3_q;
    zs4_q <= zs3_q;
    t3_q  <= SIN_C3 - {2'b0, p4[39:14]};
    q5_q  <= q4_q;
    z5_q  <= z4_q;
    t1_q  <= SIN_C1 - p5[42:14];
    sin_o <= q5_q[1] ? $signed(16'd0 - {1'b0, m}) : $signed({1'b0, m});
  end

endmodule

`default_nettype wire

[rtl/capsule_mesh_vertex_index_gen.sv]
`timescale 1ns / 1ps
`default_nettype none

// Capsule mesh element generator: one vertex or quad of the mesh per item.
// Input: an item is taken at a clock edge with start_i high and busy_o low.
// busy_o stays low, so a new item may enter on every cycle.
// Output: each result is shown for one cycle with done_o high; there is no
// back-pressure, results leave in request order.
// Throughput is one item per cycle. An item passes the restoring-division
// cells (6 for the row split, 17 for the angle and texture ratios, with the
// setup register between the two rows), the 6-stage sine pipeline, the
// normal multiply and the output register.
// Configuration: cfg_we_i writes horz_segments (index 0) or cap_segments
// (index 1, low six bits), clamped into range; write only while no item
// is in flight. Reset: segment counts return to 3 and 2, the pipeline
// empties and no result strobes until new items enter.
module capsule_mesh_vertex_index_gen import cmvig_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        func_i,
  input  wire logic [12:0] element_index_i,
  output logic             done_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [14:0]      tex_u_o,
  output logic [14:0]      tex_v_o,
  output logic [15:0]      corner_a_o,
  output logic [15:0]      corner_b_o,
  output logic [15:0]      corner_c_o,
  output logic [15:0]      corner_d_o
);

  function automatic logic signed [15:0] half14(input logic signed [15:0] s);
    logic [16:0] t;
    t = {s[15], s} + 17'd16385;
    return $signed(t[16:1] - 16'd8192);
  endfunction

  function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [31:0] p;
    logic [31:0]        mag;
    logic [31:0]        r;
    logic               neg;
    p   = a * b;
    neg = p[31];
    mag = neg ? (32'd0 - p) : p;
    r   = (mag + 32'd8192) >> 14;
    return $signed(neg ? (16'd0 - r[15:0]) : r[15:0]);
  endfunction

  // configuration
  logic [6:0] horz_q, horz_d;
  logic [5:0] cap_q, cap_d;

  always_comb begin
    horz_d = horz_q;
    cap_d  = cap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HORZ: begin
          if (cfg_wdata_i < 7'd3) horz_d = 7'd3;
          else if (cfg_wdata_i > 7'(MAX_HORZ)) horz_d = 7'(MAX_HORZ);
          else horz_d = cfg_wdata_i;
        end
        REG_CAP: begin
          if (cfg_wdata_i[5:0] < 6'd2) cap_d = 6'd2;
          else if (cfg_wdata_i[5:0] > 6'(MAX_CAP)) cap_d = 6'(MAX_CAP);
          else cap_d = cfg_wdata_i[5:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horz_q <= 7'd3;
      cap_q  <= 6'd2;
    end else begin
      horz_q <= horz_d;
      cap_q  <= cap_d;
    end
  end

  assign busy_o = 1'b0;

  // mesh sizes
  logic [6:0]  row;
  logic [7:0]  mverts;
  logic [13:0] cv_w;
  logic [12:0] cq_w;
  logic [11:0] cv, cq;

  assign row    = horz_q + 7'd1;
  assign mverts = {row, 1'b0};
  assign cv_w   = ({1'b0, cap_q} + 7'd1) * row;
  assign cq_w   = {7'b0, cap_q} * {6'b0, horz_q};
  assign cv     = cv_w[11:0];
  assign cq     = cq_w[11:0];

  // head: classify the item and set up the row split
  cell_t       hd;
  logic [13:0] l1, l2, l3, ix, k;

  always_comb begin
    if (func_i == FUNC_QUAD) begin
      l1 = {7'b0, horz_q};
      l2 = l1 + {2'b0, cq};
      l3 = l2 + {2'b0, cq};
    end else begin
      l1 = {6'b0, mverts};
      l2 = l1 + {2'b0, cv};
      l3 = l2 + {2'b0, cv};
    end
    ix = {1'b0, element_index_i};
    hd = '0;
    hd.vld      = start_i;
    hd.ctx.func = func_i;
    hd.ctx.w    = element_index_i[0];
    hd.ctx.idx  = element_index_i;
    k = '0;
    priority if (ix < l1) begin
      hd.ctx.region = RG_MANTLE;
    end else if (ix < l2) begin
      hd.ctx.region = RG_TOP;
      k = ix - l1;
    end else if (ix < l3) begin
      hd.ctx.region = RG_BOTTOM;
      k = ix - l2;
    end else begin
      hd.ctx.region = RG_NONE;
    end
    hd.lane[0].rem = {1'b0, k[11:6]};
    hd.lane[0].num = {k[5:0], 11'b0};
    hd.lane[0].quo = '0;
    hd.lane[0].den = (func_i == FUNC_QUAD) ? horz_q : row;
    hd.lane[1] = hd.lane[0];
    hd.lane[2] = hd.lane[0];
  end

  cell_t c1 [DIV1_STEPS+1];
  assign c1[0] = hd;

  for (genvar g = 0; g < DIV1_STEPS; g++) begin : g_seg1
    cmvig_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (c1[g]),
      .cell_o (c1[g+1])
    );
  end

  // setup: corners, and the three ratio divisions
  cell_t       st_d, st_q;
  logic [6:0]  sv, su, sum, sn;
  logic [22:0] x0, x1, x2;
  logic [12:0] vrow, base;
  logic [15:0] qa;

  always_comb begin
    sv   = {1'b0, c1[DIV1_STEPS].lane[0].quo[5:0]};
    su   = c1[DIV1_STEPS].lane[0].rem;
    sum  = c1[DIV1_STEPS].ctx.idx[7:1];
    st_d = c1[DIV1_STEPS];
    if (c1[DIV1_STEPS].ctx.region == RG_MANTLE) begin
      x0 = {sum, 16'b0} + {17'b0, horz_q[6:1]};
      sn = horz_q - sum;
    end else begin
      x0 = {su, 16'b0} + {17'b0, horz_q[6:1]};
      sn = su;
    end
    x1 = {sv, 16'b0} + {16'b0, cap_q[5:1], 2'b0};
    x2 = {sn, 16'b0} + {15'b0, horz_q[6:1], 2'b0};
    st_d.lane[0] = '{rem: {1'b0, x0[22:17]}, num: x0[16:0], quo: '0, den: horz_q};
    st_d.lane[1] = '{rem: {1'b0, x1[22:17]}, num: x1[16:0], quo: '0, den: {1'b0, cap_q}};
    st_d.lane[2] = '{rem: {1'b0, x2[22:17]}, num: x2[16:0], quo: '0, den: horz_q};
    vrow = sv[5:0] * row;
    base = {5'b0, mverts} + ((c1[DIV1_STEPS].ctx.region == RG_BOTTOM) ? {1'b0, cv} : 13'd0);
    if (c1[DIV1_STEPS].ctx.region == RG_MANTLE) begin
      qa = {8'b0, c1[DIV1_STEPS].ctx.idx[6:0], 1'b0};
      st_d.ctx.ca = qa + 16'd2;
      st_d.ctx.cb = qa;
      st_d.ctx.cc = qa + 16'd1;
      st_d.ctx.cd = qa + 16'd3;
    end else begin
      qa = {3'b0, base} + {3'b0, vrow} + {9'b0, su};
      st_d.ctx.ca = qa;
      st_d.ctx.cb = qa + 16'd1;
      st_d.ctx.cc = qa + {9'b0, row} + 16'd1;
      st_d.ctx.cd = qa + {9'b0, row};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  cell_t c2 [DIV2_STEPS+1];
  assign c2[0] = st_q;

  for (genvar g = 0; g < DIV2_STEPS; g++) begin : g_seg2
    cmvig_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (c2[g]),
      .cell_o (c2[g+1])
    );
  end

  // angles into the sine lanes
  ctx_t        ex_ctx;
  logic [15:0] ph, th, phi;
  logic [15:0] phase [4];

  always_comb begin
    ex_ctx    = c2[DIV2_STEPS].ctx;
    ex_ctx.tu = c2[DIV2_STEPS].lane[2].quo[16:2];
    ex_ctx.tv = c2[DIV2_STEPS].lane[1].quo[16:2];
    ph  = c2[DIV2_STEPS].lane[0].quo[15:0];
    th  = {1'b0, c2[DIV2_STEPS].lane[1].quo[16:2]};
    phi = (ex_ctx.region == RG_BOTTOM) ? (16'd16384 - ph) : (16'd16384 + ph);
    if (ex_ctx.region == RG_MANTLE) begin
      phase[0] = ph;
      phase[1] = ph + 16'd16384;
    end else begin
      phase[0] = th;
      phase[1] = th + 16'd16384;
    end
    phase[2] = phi + 16'd16384;
    phase[3] = phi;
  end

  logic signed [15:0] sn_v [4];

  for (genvar g = 0; g < 4; g++) begin : g_sin
    cmvig_sin u_sin (
      .clk_i   (clk_i),
      .phase_i (phase[g]),
      .sin_o   (sn_v[g])
    );
  end

  // context line alongside the sine pipeline
  ctx_t             ln_q [SIN_LAT];
  logic [SIN_LAT-1:0] lv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else begin
      lv_q <= {lv_q[SIN_LAT-2:0], c2[DIV2_STEPS].vld};
    end
  end

  always_ff @(posedge clk_i) begin
    ln_q[0] <= ex_ctx;
    for (int i = 1; i < SIN_LAT; i++) ln_q[i] <= ln_q[i-1];
  end

  // normal multiply
  ctx_t               mc_q;
  logic               mv_q;
  logic signed [15:0] nx_q, nz_q, s0_q, s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= lv_q[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q <= ln_q[SIN_LAT-1];
    s0_q <= sn_v[0];
    s1_q <= sn_v[1];
    nx_q <= mul14(sn_v[2], sn_v[0]);
    nz_q <= mul14(sn_v[3], sn_v[0]);
  end

  // output selection
  logic signed [15:0] px_d, py_d, pz_d, nx_d, ny_d, nz_d, cy;
  logic [14:0]        tu_d, tv_d;
  logic [15:0]        ca_d, cb_d, cc_d, cd_d;

  always_comb begin
    px_d = '0; py_d = '0; pz_d = '0;
    nx_d = '0; ny_d = '0; nz_d = '0;
    tu_d = '0; tv_d = '0;
    ca_d = '0; cb_d = '0; cc_d = '0; cd_d = '0;
    cy   = (mc_q.region == RG_BOTTOM) ? -s1_q : s1_q;
    if (mc_q.func == FUNC_QUAD) begin
      if (mc_q.region != RG_NONE) begin
        ca_d = mc_q.ca;
        cb_d = mc_q.cb;
        cc_d = mc_q.cc;
        cd_d = mc_q.cd;
      end
    end else begin
      unique case (mc_q.region)
        RG_MANTLE: begin
          px_d = half14(s0_q);
          py_d = mc_q.w ? -16'sd8192 : 16'sd8192;
          pz_d = half14(s1_q);
          nx_d = s0_q;
          nz_d = s1_q;
          tu_d = mc_q.tu;
          tv_d = mc_q.w ? 15'd16384 : 15'd0;
        end
        RG_TOP, RG_BOTTOM: begin
          nx_d = nx_q;
          ny_d = cy;
          nz_d = nz_q;
          px_d = half14(nx_q);
          py_d = half14(cy) + ((mc_q.region == RG_BOTTOM) ? -16'sd8192 : 16'sd8192);
          pz_d = half14(nz_q);
          tu_d = mc_q.tu;
          tv_d = mc_q.tv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_o    <= px_d;
    pos_y_o    <= py_d;
    pos_z_o    <= pz_d;
    norm_x_o   <= nx_d;
    norm_y_o   <= ny_d;
    norm_z_o   <= nz_d;
    tex_u_o    <= tu_d;
    tex_v_o    <= tv_d;
    corner_a_o <= ca_d;
    corner_b_o <= cb_d;
    corner_c_o <= cc_d;
    corner_d_o <= cd_d;
  end

endmodule

`default_nettype wire

[rtl/cmvig_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmvig_chk import cmvig_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic signed [15:0] pos_x_o,
  input wire logic signed [15:0] pos_y_o,
  input wire logic signed [15:0] norm_x_o,
  input wire logic [14:0] tex_u_o,
  input wire logic [14:0] tex_v_o,
  input wire logic [15:0] corner_a_o
);

  // every accepted item comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted item produced no result");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without an accepted item");

  a_quad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (corner_a_o != 16'd0)) |->
      (pos_x_o == 16'sd0 && pos_y_o == 16'sd0 && norm_x_o == 16'sd0 &&
       tex_u_o == 15'd0 && tex_v_o == 15'd0))
    else $error("quad result carries vertex fields");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tex_u_o <= 15'd16384 && tex_v_o <= 15'd16384))
    else $error("texture coordinate above one");

endmodule

bind capsule_mesh_vertex_index_gen cmvig_chk u_chk (.*);

`default_nettype wire
